// File: sv/pit_pkg.sv
// ----------------------------------------------------------------------------
// pit_pkg
// Widths and types for the point-in-triangle test.
// ----------------------------------------------------------------------------
package pit_pkg;

  localparam int COORD_WIDTH = 16;
  // vertex differences need one more bit
  localparam int DIFF_WIDTH  = COORD_WIDTH + 1;
  // product of two differences
  localparam int PROD_WIDTH  = 2 * DIFF_WIDTH;
  // difference of two products (cross product)
  localparam int CROSS_WIDTH = PROD_WIDTH + 1;
  // a + b - c
  localparam int SUM_WIDTH   = CROSS_WIDTH + 2;

  typedef logic signed [COORD_WIDTH-1:0] coord_t;
  typedef logic signed [DIFF_WIDTH-1:0]  diff_t;
  typedef logic signed [PROD_WIDTH-1:0]  prod_t;
  typedef logic signed [CROSS_WIDTH-1:0] cross_t;
  typedef logic signed [SUM_WIDTH-1:0]   sum_t;

endpackage

// File: sv/point_in_triangle_test.sv
// ----------------------------------------------------------------------------
// point_in_triangle_test
// Strict barycentric point-in-triangle test in exact integer arithmetic.
// ----------------------------------------------------------------------------
// pipeline: an accepted request passes through registered difference,
//   product, cross and compare stages before its result shows at the output
// throughput: one request per cycle; the whole pipeline holds while a
//   finished result waits at the output under stall
// reset: synchronous, clears every stage valid bit; data registers keep state
module point_in_triangle_test (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  pit_pkg::coord_t        vertex0_x,
  input  pit_pkg::coord_t        vertex0_y,
  input  pit_pkg::coord_t        vertex1_x,
  input  pit_pkg::coord_t        vertex1_y,
  input  pit_pkg::coord_t        vertex2_x,
  input  pit_pkg::coord_t        vertex2_y,
  input  pit_pkg::coord_t        query_x,
  input  pit_pkg::coord_t        query_y,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic                   inside_res,
  output logic                   degenerate
);

  logic advance;

  // stage 1: edge vectors from vertex 0
  logic            s1_valid;
  pit_pkg::diff_t  e0x, e0y, e1x, e1y, px, py;

  // stage 2: six products
  logic            s2_valid;
  pit_pkg::prod_t  mul_c1, mul_c2, mul_a1, mul_a2, mul_b1, mul_b2;

  // stage 3: cross products
  logic            s3_valid;
  pit_pkg::cross_t cross_c, cross_a, cross_b;

  // stage 4 logic
  pit_pkg::sum_t   sum_abc;
  logic            c_pos, c_neg, hit_next;

  // one pipeline-wide enable: only a held result blocks
  assign advance  = !(out_valid && out_stall);
  assign in_stall = !advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      s2_valid  <= 1'b0;
      s3_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else if (advance) begin
      s1_valid  <= in_valid;
      s2_valid  <= s1_valid;
      s3_valid  <= s2_valid;
      out_valid <= s3_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      e0x <= pit_pkg::diff_t'(vertex2_x) - pit_pkg::diff_t'(vertex0_x);
      e0y <= pit_pkg::diff_t'(vertex2_y) - pit_pkg::diff_t'(vertex0_y);
      e1x <= pit_pkg::diff_t'(vertex1_x) - pit_pkg::diff_t'(vertex0_x);
      e1y <= pit_pkg::diff_t'(vertex1_y) - pit_pkg::diff_t'(vertex0_y);
      px  <= pit_pkg::diff_t'(query_x)   - pit_pkg::diff_t'(vertex0_x);
      py  <= pit_pkg::diff_t'(query_y)   - pit_pkg::diff_t'(vertex0_y);
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      mul_c1 <= pit_pkg::prod_t'(e0x) * pit_pkg::prod_t'(e1y);
      mul_c2 <= pit_pkg::prod_t'(e0y) * pit_pkg::prod_t'(e1x);
      mul_a1 <= pit_pkg::prod_t'(px)  * pit_pkg::prod_t'(e1y);
      mul_a2 <= pit_pkg::prod_t'(py)  * pit_pkg::prod_t'(e1x);
      mul_b1 <= pit_pkg::prod_t'(e0x) * pit_pkg::prod_t'(py);
      mul_b2 <= pit_pkg::prod_t'(e0y) * pit_pkg::prod_t'(px);
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      cross_c <= pit_pkg::cross_t'(mul_c1) - pit_pkg::cross_t'(mul_c2);
      cross_a <= pit_pkg::cross_t'(mul_a1) - pit_pkg::cross_t'(mul_a2);
      cross_b <= pit_pkg::cross_t'(mul_b1) - pit_pkg::cross_t'(mul_b2);
    end
  end

  // hit when a, b, c share a strict sign and a + b lies strictly short of c
  always_comb begin
    sum_abc  = pit_pkg::sum_t'(cross_a) + pit_pkg::sum_t'(cross_b)
             - pit_pkg::sum_t'(cross_c);
    c_pos    = (cross_c > 0);
    c_neg    = (cross_c < 0);
    hit_next = (c_pos && (cross_a > 0) && (cross_b > 0) && (sum_abc < 0)) ||
               (c_neg && (cross_a < 0) && (cross_b < 0) && (sum_abc > 0));
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      inside_res <= hit_next;
      degenerate <= !c_pos && !c_neg;
    end
  end

endmodule

// File: sv/pit_checker.sv
// ----------------------------------------------------------------------------
// pit_checker
// Port-level checks on the point-in-triangle test, bound to the top level.
// ----------------------------------------------------------------------------
module pit_checker (
  input logic clk,
  input logic rst,
  input logic in_stall,
  input logic out_valid,
  input logic out_stall,
  input logic inside_res,
  input logic degenerate
);

  // a degenerate triangle never reports a hit
  a_no_hit_when_degenerate: assert property (
    @(posedge clk) disable iff (rst)
    out_valid |-> !(inside_res && degenerate))
    else $error("hit reported for degenerate triangle");

  // input side is held back only by a held result
  a_stall_only_on_backpressure: assert property (
    @(posedge clk) disable iff (rst)
    in_stall |-> (out_valid && out_stall))
    else $error("input stalled without output backpressure");

  // nothing comes out right after reset
  a_quiet_after_reset: assert property (
    @(posedge clk)
    rst |=> !out_valid)
    else $error("result shown right after reset");

  // a stalled result stays put
  a_result_holds: assert property (
    @(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=>
      (out_valid && $stable(inside_res) && $stable(degenerate)))
    else $error("stalled result changed");

endmodule

bind point_in_triangle_test pit_checker u_pit_checker (.*);
